// ===== rtl/lkc_pkg.sv =====
// shared constants and types for the lru key-value cache
package lkc_pkg;

  // number of cache entries
  localparam int DEPTH = 16;

  // field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // derived widths for entry index, recency rank and entry count
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // value returned by a get that misses
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  // one request transaction
  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // one response transaction
  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } rsp_t;

endpackage

// ===== rtl/lkc_req_if.sv =====
// request channel interface: valid/ready handshake with mode, key and value
interface lkc_req_if;

  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic signed [lkc_pkg::KEY_W-1:0]        key;
  logic signed [lkc_pkg::VAL_W-1:0]        value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);

endinterface

// ===== rtl/lkc_rsp_if.sv =====
// response channel interface: valid/ready handshake with hit, read value and evicted flag
interface lkc_rsp_if;

  logic                                    valid;
  logic                                    ready;
  logic                                    hit;
  logic signed [lkc_pkg::VAL_W-1:0]        read_value;
  logic                                    evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted, output ready);

endinterface

// ===== rtl/lkc_store.sv =====
// entry storage with parallel key match, lru selection and recency update
module lkc_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lkc_pkg::CNT_W-1:0]     capacity,
  input  logic                          op_en,
  input  lkc_pkg::req_t                 req,
  output lkc_pkg::rsp_t                 rsp
);

  // entry state
  logic [lkc_pkg::KEY_W-1:0] key_r   [lkc_pkg::DEPTH];
  logic [lkc_pkg::VAL_W-1:0] val_r   [lkc_pkg::DEPTH];
  logic [lkc_pkg::DEPTH-1:0] valid_r;
  logic [lkc_pkg::DEPTH-1:0] valid_nxt;
  logic [lkc_pkg::AGE_W-1:0] age_r   [lkc_pkg::DEPTH];
  logic [lkc_pkg::AGE_W-1:0] age_nxt [lkc_pkg::DEPTH];
  logic [lkc_pkg::CNT_W-1:0] occ_r;
  logic [lkc_pkg::CNT_W-1:0] occ_nxt;

  logic [lkc_pkg::DEPTH-1:0] match_oh;
  logic [lkc_pkg::DEPTH-1:0] lru_oh;
  logic [lkc_pkg::DEPTH-1:0] free_oh;
  logic [lkc_pkg::DEPTH-1:0] slot_oh;
  logic [lkc_pkg::AGE_W-1:0] hit_age;
  logic [lkc_pkg::VAL_W-1:0] hit_val;
  logic [lkc_pkg::CNT_W-1:0] lru_age;
  logic                      hit;
  logic                      is_put;
  logic                      full;
  logic                      use_evict;
  logic                      do_insert;
  logic                      free_seen;

  // parallel key compare and value/age read of the matching entry
  always_comb begin
    match_oh = '0;
    hit_age  = '0;
    hit_val  = '0;
    for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
      match_oh[i] = valid_r[i] && (key_r[i] == req.key);
      hit_age     = hit_age | (match_oh[i] ? age_r[i] : '0);
      hit_val     = hit_val | (match_oh[i] ? val_r[i] : '0);
    end
  end

  assign hit    = |match_oh;
  assign is_put = (req.mode == lkc_pkg::MODE_PUT);

  // least recent entry holds rank occupancy-1, ranks being distinct
  assign lru_age = occ_r - lkc_pkg::CNT_W'(1);
  assign full    = (occ_r >= capacity);

  always_comb begin
    for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
      lru_oh[i] = valid_r[i] && (lkc_pkg::CNT_W'(age_r[i]) == lru_age);
    end
  end

  // first free entry, lowest index wins
  always_comb begin
    free_oh   = '0;
    free_seen = 1'b0;
    for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
      free_oh[i] = !valid_r[i] && !free_seen;
      free_seen  = free_seen || !valid_r[i];
    end
  end

  // target entry for a put of a new key
  assign use_evict = full && (|lru_oh);
  assign slot_oh   = use_evict ? lru_oh : free_oh;
  assign do_insert = op_en && is_put && !hit && (|slot_oh);

  // response fields
  always_comb begin
    rsp.hit        = hit;
    rsp.evicted    = is_put && !hit && use_evict;
    rsp.read_value = '0;
    if (!is_put) begin
      rsp.read_value = hit ? $signed(hit_val) : lkc_pkg::MISS_VALUE;
    end
  end

  // next valid bits, ranks and occupancy
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
      age_nxt[i] = age_r[i];
      if (op_en && hit) begin
        if (match_oh[i]) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (age_r[i] < hit_age)) begin
          age_nxt[i] = age_r[i] + lkc_pkg::AGE_W'(1);
        end
      end else if (do_insert) begin
        if (slot_oh[i]) begin
          age_nxt[i]   = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + lkc_pkg::AGE_W'(1);
        end
      end
    end
    if (do_insert && !use_evict) begin
      occ_nxt = occ_r + lkc_pkg::CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  // key and value payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < lkc_pkg::DEPTH; i++) begin
      if (do_insert && slot_oh[i]) begin
        key_r[i] <= req.key;
        val_r[i] <= req.value;
      end else if (op_en && is_put && match_oh[i]) begin
        val_r[i] <= req.value;
      end
    end
  end

`ifndef SYNTHESIS
  // keys among valid entries stay unique
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_oh))
    else $error("more than one entry matches the key");

  // occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match valid entries");

  // a non-empty cache always has a single least recent entry to evict
  a_lru_found: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != '0) |-> $onehot(lru_oh))
    else $error("no unique least recent entry");

  // a put of a new key leaves the cache non-empty
  a_put_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (op_en && is_put && !hit) |=> ($countones(valid_r) >= 1))
    else $error("put of new key left cache empty");
`endif

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// top level of the lru key-value cache: handshake, capacity register, result register
//
// Fully associative key-value cache with least-recently-used replacement.
// in_ch carries request transactions: mode (get or put), key and value.
// out_ch carries one response transaction per request: hit, read_value
// (stored value on a get hit, -1 on a get miss, 0 on a put) and evicted.
// cfg_wr_en/cfg_wr_data write the capacity register (clamped to 1..16);
// write it only while no request is in flight, normally right after reset.
// A request accepted on in_ch is captured in an input register; the full
// lookup and update then run on it and load the result register, which
// drives out_ch. Throughput: one request per cycle while the receiver
// takes each result, set by the parallel key compare and recency update
// over all 16 entries.
// Reset: all entries invalid, occupancy zero, capacity 16, both channels
// empty. When the receiver stalls, the result register holds its
// transaction and the input register takes one more request; further
// requests wait until the result is taken.
module lru_key_value_cache_core (
  input  logic                        clk,
  input  logic                        rst_n,
  lkc_req_if.sink                     in_ch,
  lkc_rsp_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [lkc_pkg::CFG_W-1:0]   cfg_wr_data
);

  logic                        in_v_r;
  logic                        in_v_nxt;
  lkc_pkg::req_t               in_r;
  logic                        out_v_r;
  logic                        out_v_nxt;
  lkc_pkg::rsp_t               out_r;
  lkc_pkg::rsp_t               rsp;
  logic [lkc_pkg::CNT_W-1:0]   cap_r;
  logic [lkc_pkg::CNT_W-1:0]   cap_nxt;
  logic [31:0]                 cfg_wide;
  logic                        in_fire;
  logic                        proc_en;

  // handshake control
  assign proc_en     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || proc_en;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (proc_en) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (proc_en) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // capacity clamp to 1..DEPTH
  assign cfg_wide = 32'(cfg_wr_data);

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr_en) begin
      if (cfg_wide == 32'd0) begin
        cap_nxt = lkc_pkg::CNT_W'(1);
      end else if (cfg_wide > 32'(lkc_pkg::DEPTH)) begin
        cap_nxt = lkc_pkg::CNT_W'(lkc_pkg::DEPTH);
      end else begin
        cap_nxt = lkc_pkg::CNT_W'(cfg_wide);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cap_r   <= lkc_pkg::CNT_W'(lkc_pkg::DEPTH);
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      cap_r   <= cap_nxt;
    end
  end

  // request and response payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r.mode  <= in_ch.mode;
      in_r.key   <= in_ch.key;
      in_r.value <= in_ch.value;
    end
    if (proc_en) begin
      out_r <= rsp;
    end
  end

  // lookup, replacement and recency update
  lkc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (cap_r),
    .op_en    (proc_en),
    .req      (in_r),
    .rsp      (rsp)
  );

  // response channel
  assign out_ch.valid      = out_v_r;
  assign out_ch.hit        = out_r.hit;
  assign out_ch.read_value = out_r.read_value;
  assign out_ch.evicted    = out_r.evicted;

`ifndef SYNTHESIS
  // capacity stays within 1..DEPTH
  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (32'(cap_r) <= 32'(lkc_pkg::DEPTH)))
    else $error("capacity out of range");

  // a held request is not lost while the result register is stalled
  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !proc_en) |=> (in_v_r && $stable(in_r)))
    else $error("pending request dropped during stall");

  // a processed request always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en |=> out_v_r)
    else $error("processed request produced no response");
`endif

endmodule
